[rtl/cfs_pkg.sv]
package cfs_pkg;

  localparam logic [7:0] QUOTE_CHAR = 8'h22;
  localparam logic [7:0] COMMA_CHAR = 8'h2C;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       field_done;
    logic       trim_ends;
    logic       line_done;
  } result_t;

  // one accepted word: one or two results
  typedef struct packed {
    logic    two;
    result_t first;
    result_t second;
  } job_t;

endpackage

[rtl/cfs_front.sv]
module cfs_front
  import cfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] char_code,
  input  logic       char_present,
  input  logic       end_of_line,
  input  logic       push,
  output logic       full,
  input  logic       queue_full,
  output logic       job_push,
  output job_t       job
);

  logic in_quotes, quote_pending, saw_quote, field_nonempty, first_is_quote, last_is_quote;
  logic in_quotes_next, quote_pending_next, saw_quote_next;
  logic field_nonempty_next, first_is_quote_next, last_is_quote_next;
  logic [1:0] count;
  job_t job_comb;

  assign full = queue_full;

  always_comb begin
    logic       handled;
    logic       emit_char;
    logic       emit_end;
    logic [7:0] ch;
    logic       is_quote;
    logic       trim;
    result_t    r_char;
    result_t    r_end;
    result_t    r_line;

    in_quotes_next      = in_quotes;
    quote_pending_next  = quote_pending;
    saw_quote_next      = saw_quote;
    field_nonempty_next = field_nonempty;
    first_is_quote_next = first_is_quote;
    last_is_quote_next  = last_is_quote;
    handled   = 1'b0;
    emit_char = 1'b0;
    emit_end  = 1'b0;
    ch        = char_code;
    is_quote  = (char_code == QUOTE_CHAR);
    trim      = 1'b0;
    r_char    = '0;
    r_end     = '0;
    r_line    = '0;
    count     = 2'd0;
    job_comb  = '0;

    if (char_present) begin
      if (quote_pending) begin
        quote_pending_next = 1'b0;
        if (is_quote) begin
          emit_char = 1'b1;
          ch        = QUOTE_CHAR;
          handled   = 1'b1;
        end else begin
          in_quotes_next = 1'b0;
        end
      end
      if (!handled) begin
        if (is_quote) begin
          saw_quote_next = 1'b1;
          if (in_quotes_next) begin
            quote_pending_next = 1'b1;
          end else begin
            in_quotes_next = 1'b1;
          end
        end else if (char_code == COMMA_CHAR && !in_quotes_next) begin
          emit_end = 1'b1;
        end else begin
          emit_char = 1'b1;
        end
      end
    end

    // character word
    if (emit_char) begin
      if (!field_nonempty_next) begin
        first_is_quote_next = (ch == QUOTE_CHAR);
      end
      last_is_quote_next  = (ch == QUOTE_CHAR);
      field_nonempty_next = 1'b1;
      r_char.out_char     = ch;
      r_char.char_valid   = 1'b1;
    end

    // field end by comma
    if (emit_end) begin
      trim = saw_quote_next && field_nonempty_next && first_is_quote_next && last_is_quote_next;
      r_end.field_done = 1'b1;
      r_end.trim_ends  = trim;
      in_quotes_next      = 1'b0;
      quote_pending_next  = 1'b0;
      saw_quote_next      = 1'b0;
      field_nonempty_next = 1'b0;
      first_is_quote_next = 1'b0;
      last_is_quote_next  = 1'b0;
    end

    // field end by line end
    if (end_of_line) begin
      trim = saw_quote_next && field_nonempty_next && first_is_quote_next && last_is_quote_next;
      r_line.field_done = 1'b1;
      r_line.trim_ends  = trim;
      r_line.line_done  = 1'b1;
      in_quotes_next      = 1'b0;
      quote_pending_next  = 1'b0;
      saw_quote_next      = 1'b0;
      field_nonempty_next = 1'b0;
      first_is_quote_next = 1'b0;
      last_is_quote_next  = 1'b0;
    end

    if (emit_char || emit_end) begin
      job_comb.first = emit_char ? r_char : r_end;
      if (end_of_line) begin
        job_comb.two    = 1'b1;
        job_comb.second = r_line;
        count           = 2'd2;
      end else begin
        count = 2'd1;
      end
    end else if (end_of_line) begin
      job_comb.first = r_line;
      count          = 2'd1;
    end
  end

  assign job      = job_comb;
  assign job_push = push && !queue_full && (count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_quotes      <= 1'b0;
      quote_pending  <= 1'b0;
      saw_quote      <= 1'b0;
      field_nonempty <= 1'b0;
      first_is_quote <= 1'b0;
      last_is_quote  <= 1'b0;
    end else if (push && !queue_full) begin
      in_quotes      <= in_quotes_next;
      quote_pending  <= quote_pending_next;
      saw_quote      <= saw_quote_next;
      field_nonempty <= field_nonempty_next;
      first_is_quote <= first_is_quote_next;
      last_is_quote  <= last_is_quote_next;
    end
  end

endmodule

[rtl/cfs_queue.sv]
module cfs_queue
  import cfs_pkg::*;
#(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  job_t wr_job,
  output logic q_full,
  input  logic rd_en,
  output job_t rd_job,
  output logic q_empty
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(Depth - 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(Depth);

  job_t          mem [Depth];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr, do_rd;

  assign q_full  = (count == DEPTH_CNT);
  assign q_empty = (count == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_job  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/cfs_back.sv]
module cfs_back
  import cfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  job_t       head,
  input  logic       head_empty,
  output logic       head_pop,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char,
  output logic       char_valid,
  output logic       field_done,
  output logic       trim_ends,
  output logic       line_done,
  output logic       last_result
);

  logic    sel;
  result_t cur;
  logic    take;

  assign cur         = sel ? head.second : head.first;
  assign empty       = head_empty;
  assign take        = pop && !head_empty;
  assign last_result = !head.two || sel;
  assign head_pop    = take && last_result;

  assign out_char   = cur.out_char;
  assign char_valid = cur.char_valid;
  assign field_done = cur.field_done;
  assign trim_ends  = cur.trim_ends;
  assign line_done  = cur.line_done;

  // second word of a two-result job
  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= 1'b0;
    end else if (take) begin
      sel <= !last_result;
    end
  end

endmodule

[rtl/csv_field_splitter_top.sv]
// csv field splitter
// input channel: push / full with char_code, char_present, end_of_line; one
//   character of a text line per word, end_of_line closes the final field
// result channel: empty / pop; a result is either one field character
//   (char_valid) or a field end (field_done, trim_ends, line_done);
//   last_result marks the final result of an input word
// a word gives zero, one or two results; words with no result push no job
//   into the queue; a result is written into the job queue when its input
//   word is accepted and reaches the outputs once the results ahead are popped
// throughput: one input word per cycle while the job queue has room, one
//   result per cycle out while the receiver pops; words with two results take
//   two pops, so the sustained rate is set by the single result port
// stall: the job queue holds QueueDepth words; when the receiver stops
//   popping the queue fills and full rises, parser state holds
// reset: clears quoting and field state and empties the queue
module csv_field_splitter_top
  import cfs_pkg::*;
#(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_code,
  input  logic       char_present,
  input  logic       end_of_line,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char,
  output logic       char_valid,
  output logic       field_done,
  output logic       trim_ends,
  output logic       line_done,
  output logic       last_result
);

  job_t wr_job, rd_job;
  logic job_push, q_full, q_empty, head_pop;

  cfs_front u_front (
    .clk          (clk),
    .rst          (rst),
    .char_code    (char_code),
    .char_present (char_present),
    .end_of_line  (end_of_line),
    .push         (push),
    .full         (full),
    .queue_full   (q_full),
    .job_push     (job_push),
    .job          (wr_job)
  );

  cfs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_push),
    .wr_job  (wr_job),
    .q_full  (q_full),
    .rd_en   (head_pop),
    .rd_job  (rd_job),
    .q_empty (q_empty)
  );

  cfs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (rd_job),
    .head_empty  (q_empty),
    .head_pop    (head_pop),
    .empty       (empty),
    .pop         (pop),
    .out_char    (out_char),
    .char_valid  (char_valid),
    .field_done  (field_done),
    .trim_ends   (trim_ends),
    .line_done   (line_done),
    .last_result (last_result)
  );

endmodule

[tb/csv_field_splitter_chk.sv]
`timescale 1ns / 1ps

module csv_field_splitter_chk
  import cfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       full,
  input  logic [7:0] char_code,
  input  logic       char_present,
  input  logic       end_of_line,
  input  logic       empty,
  input  logic       pop,
  input  logic [7:0] out_char,
  input  logic       char_valid,
  input  logic       field_done,
  input  logic       trim_ends,
  input  logic       line_done,
  input  logic       last_result,
  output int         err_count,
  output int         pending,
  output int         chars_seen,
  output int         fields_seen,
  output int         trims_seen,
  output int         lines_seen
);

  typedef struct packed {
    result_t body;
    logic    last;
  } token_t;

  token_t token_q[$];

  logic quoting;
  logic quote_held;
  logic had_quote;
  logic has_chars;
  logic starts_quote;
  logic ends_quote;

  task automatic clear_field();
    quoting      = 1'b0;
    quote_held   = 1'b0;
    had_quote    = 1'b0;
    has_chars    = 1'b0;
    starts_quote = 1'b0;
    ends_quote   = 1'b0;
  endtask

  task automatic emit_char(input logic [7:0] c);
    token_t t;
    if (!has_chars) begin
      starts_quote = (c == QUOTE_CHAR);
    end
    ends_quote = (c == QUOTE_CHAR);
    has_chars = 1'b1;
    t = '0;
    t.body.out_char = c;
    t.body.char_valid = 1'b1;
    token_q.push_back(t);
  endtask

  task automatic emit_end(input logic eol);
    token_t t;
    t = '0;
    t.body.field_done = 1'b1;
    t.body.trim_ends = had_quote && has_chars && starts_quote && ends_quote;
    t.body.line_done = eol;
    token_q.push_back(t);
    clear_field();
  endtask

  task automatic split_char(input logic [7:0] c, input logic present, input logic eol);
    int   start_size;
    logic taken;
    start_size = token_q.size();
    taken = 1'b0;
    if (present) begin
      if (quote_held) begin
        quote_held = 1'b0;
        if (c == QUOTE_CHAR) begin
          emit_char(QUOTE_CHAR);
          taken = 1'b1;
        end else begin
          quoting = 1'b0;
        end
      end
      if (!taken) begin
        if (c == QUOTE_CHAR) begin
          had_quote = 1'b1;
          if (quoting) begin
            quote_held = 1'b1;
          end else begin
            quoting = 1'b1;
          end
        end else if (c == COMMA_CHAR && !quoting) begin
          emit_end(1'b0);
        end else begin
          emit_char(c);
        end
      end
    end
    if (eol) begin
      emit_end(1'b1);
    end
    if (token_q.size() > start_size) begin
      token_q[token_q.size() - 1].last = 1'b1;
    end
  endtask

  task automatic check_token();
    token_t w;
    if (token_q.size() == 0) begin
      $error("unexpected result word: out_char %0h char_valid %0b field_done %0b",
             out_char, char_valid, field_done);
      err_count++;
    end else begin
      w = token_q.pop_front();
      if (out_char !== w.body.out_char) begin
        $error("out_char: expected %0h, got %0h", w.body.out_char, out_char);
        err_count++;
      end
      if (char_valid !== w.body.char_valid) begin
        $error("char_valid: expected %0b, got %0b", w.body.char_valid, char_valid);
        err_count++;
      end
      if (field_done !== w.body.field_done) begin
        $error("field_done: expected %0b, got %0b", w.body.field_done, field_done);
        err_count++;
      end
      if (trim_ends !== w.body.trim_ends) begin
        $error("trim_ends: expected %0b, got %0b", w.body.trim_ends, trim_ends);
        err_count++;
      end
      if (line_done !== w.body.line_done) begin
        $error("line_done: expected %0b, got %0b", w.body.line_done, line_done);
        err_count++;
      end
      if (last_result !== w.last) begin
        $error("last_result: expected %0b, got %0b", w.last, last_result);
        err_count++;
      end
      chars_seen  += w.body.char_valid;
      fields_seen += w.body.field_done;
      trims_seen  += w.body.trim_ends;
      lines_seen  += w.body.line_done;
    end
  endtask

  initial begin
    err_count   = 0;
    pending     = 0;
    chars_seen  = 0;
    fields_seen = 0;
    trims_seen  = 0;
    lines_seen  = 0;
    clear_field();
  end

  always @(posedge clk) begin
    if (rst) begin
      clear_field();
      token_q.delete();
    end else begin
      if (pop && !empty) begin
        check_token();
      end
      if (push && !full) begin
        split_char(char_code, char_present, end_of_line);
      end
    end
    pending <= token_q.size();
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb
  import cfs_pkg::*;
();

  localparam int WordTarget = 500;
  localparam int CycleLimit = 200000;
  localparam int HoldAfter  = 40;
  localparam int HoldCycles = 80;

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  logic [7:0] char_code;
  logic       char_present;
  logic       end_of_line;
  logic       empty;
  logic       pop;
  logic [7:0] out_char;
  logic       char_valid;
  logic       field_done;
  logic       trim_ends;
  logic       line_done;
  logic       last_result;

  int err_count;
  int pending;
  int chars_seen;
  int fields_seen;
  int trims_seen;
  int lines_seen;
  int words_sent;
  int cycle_count;
  logic push_burst;
  logic pop_burst;

  csv_field_splitter_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .char_code   (char_code),
    .char_present(char_present),
    .end_of_line (end_of_line),
    .empty       (empty),
    .pop         (pop),
    .out_char    (out_char),
    .char_valid  (char_valid),
    .field_done  (field_done),
    .trim_ends   (trim_ends),
    .line_done   (line_done),
    .last_result (last_result)
  );

  csv_field_splitter_chk i_chk (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .char_code   (char_code),
    .char_present(char_present),
    .end_of_line (end_of_line),
    .empty       (empty),
    .pop         (pop),
    .out_char    (out_char),
    .char_valid  (char_valid),
    .field_done  (field_done),
    .trim_ends   (trim_ends),
    .line_done   (line_done),
    .last_result (last_result),
    .err_count   (err_count),
    .pending     (pending),
    .chars_seen  (chars_seen),
    .fields_seen (fields_seen),
    .trims_seen  (trims_seen),
    .lines_seen  (lines_seen)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_word(input logic [7:0] c, input logic present, input logic eol);
    int gap;
    gap = push_burst ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push         <= 1'b1;
    char_code    <= c;
    char_present <= present;
    end_of_line  <= eol;
    do @(posedge clk); while (full);
    if (present || eol) begin
      words_sent++;
      if (words_sent % 32 == 0) begin
        push_burst = ($urandom_range(0, 3) == 0);
      end
    end
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == QUOTE_CHAR || c == COMMA_CHAR);
    return c;
  endfunction

  task automatic send_line();
    int nf;
    int len;
    int pick;
    nf = $urandom_range(1, 4);
    for (int f = 0; f < nf; f++) begin
      if (f > 0) begin
        send_word(COMMA_CHAR, 1'b1, 1'b0);
      end
      len = $urandom_range(0, 3);
      if ($urandom_range(0, 2) != 0) begin
        send_word(QUOTE_CHAR, 1'b1, 1'b0);
        for (int k = 0; k < len; k++) begin
          pick = $urandom_range(0, 5);
          if (pick < 2) begin
            send_word(QUOTE_CHAR, 1'b1, 1'b0);
            send_word(QUOTE_CHAR, 1'b1, 1'b0);
          end else if (pick == 2) begin
            send_word(COMMA_CHAR, 1'b1, 1'b0);
          end else begin
            send_word(plain_char(), 1'b1, 1'b0);
          end
        end
        if ($urandom_range(0, 9) != 0) begin
          send_word(QUOTE_CHAR, 1'b1, 1'b0);
        end
      end else begin
        for (int k = 0; k < len; k++) begin
          send_word(plain_char(), 1'b1, 1'b0);
        end
      end
      if ($urandom_range(0, 9) == 0) begin
        send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
    end
    case ($urandom_range(0, 3))
      0: send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      1: send_word(plain_char(), 1'b1, 1'b1);
      2: send_word(COMMA_CHAR, 1'b1, 1'b1);
      default: send_word(QUOTE_CHAR, 1'b1, 1'b1);
    endcase
  endtask

  // receiver: random pops, one long hold-off to back up the queue
  initial begin
    int gap;
    int popped;
    logic held;
    popped = 0;
    held = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (!held && popped == HoldAfter) begin
        held = 1'b1;
        pop <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      gap = pop_burst ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      popped++;
      if (popped % 30 == 0) begin
        pop_burst = ($urandom_range(0, 3) == 0);
      end
    end
  end

  initial begin
    cycle_count  = 0;
    words_sent   = 0;
    push_burst   = 1'b0;
    pop_burst    = 1'b0;
    rst          = 1'b1;
    push         = 1'b0;
    pop          = 1'b0;
    char_code    = 8'h00;
    char_present = 1'b0;
    end_of_line  = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // extremes, doubled quotes, comma after held quote on the line end
    send_word(8'h00, 1'b0, 1'b0);
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'hFF, 1'b1, 1'b0);
    send_word(COMMA_CHAR, 1'b1, 1'b0);
    send_word(QUOTE_CHAR, 1'b1, 1'b0);
    send_word(QUOTE_CHAR, 1'b1, 1'b0);
    send_word(QUOTE_CHAR, 1'b1, 1'b0);
    send_word(8'h78, 1'b1, 1'b0);
    send_word(QUOTE_CHAR, 1'b1, 1'b0);
    send_word(QUOTE_CHAR, 1'b1, 1'b0);
    send_word(QUOTE_CHAR, 1'b1, 1'b0);
    send_word(COMMA_CHAR, 1'b1, 1'b1);
    // empty word, then quotes left open at the line end
    send_word(8'hFF, 1'b0, 1'b0);
    send_word(QUOTE_CHAR, 1'b1, 1'b0);
    send_word(COMMA_CHAR, 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);
    // held quote at the line end
    send_word(QUOTE_CHAR, 1'b1, 1'b0);
    send_word(8'h62, 1'b1, 1'b0);
    send_word(QUOTE_CHAR, 1'b1, 1'b0);
    send_word(8'hFF, 1'b0, 1'b1);
    // one literal quote inside quotes, closed by the line end
    send_word(QUOTE_CHAR, 1'b1, 1'b0);
    send_word(QUOTE_CHAR, 1'b1, 1'b0);
    send_word(QUOTE_CHAR, 1'b1, 1'b0);
    send_word(8'h71, 1'b1, 1'b1);

    while (words_sent < WordTarget) begin
      if ($urandom_range(0, 6) == 0) begin
        send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  $urandom_range(0, 7) == 0);
      end else begin
        send_line();
      end
    end
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("sent %0d words; got %0d characters and %0d field ends", words_sent,
             chars_seen, fields_seen);
    $display("%0d field ends flagged for trim, %0d closed by a line end", trims_seen,
             lines_seen);
    if (err_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[csv_field_splitter_top.f]
rtl/cfs_pkg.sv
rtl/cfs_front.sv
rtl/cfs_queue.sv
rtl/cfs_back.sv
rtl/csv_field_splitter_top.sv
tb/csv_field_splitter_chk.sv
tb/tb.sv
